>>> design/jcs_pkg.sv
`timescale 1ns / 1ps
package jcs_pkg;

  localparam int MAX_JETS_DEF = 6;
  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_JET = 2'd0;
  localparam logic [1:0] CMD_MUON = 2'd1;
  localparam logic [1:0] CMD_RUN = 2'd2;

  localparam logic [2:0] REG_TOP_MASS = 3'd0;
  localparam logic [2:0] REG_W_MASS = 3'd1;
  localparam logic [2:0] REG_LEP_B_MASS = 3'd2;
  localparam logic [2:0] REG_W_WEIGHT = 3'd3;
  localparam logic [2:0] REG_TOP_WEIGHT = 3'd4;
  localparam logic [2:0] REG_LEP_B_WEIGHT = 3'd5;
  localparam logic [2:0] REG_PT_MIN = 3'd6;
  localparam logic [2:0] REG_ETA_MAX = 3'd7;

  localparam logic [15:0] TOP_MASS_RST = 16'd2758;
  localparam logic [15:0] W_MASS_RST = 16'd1286;
  localparam logic [15:0] LEP_B_MASS_RST = 16'd1458;
  localparam logic [15:0] W_WEIGHT_RST = 16'd1135;
  localparam logic [15:0] TOP_WEIGHT_RST = 16'd419;
  localparam logic [15:0] LEP_B_WEIGHT_RST = 16'd51;
  localparam logic [19:0] PT_MIN_RST = 20'd480;
  localparam logic [12:0] ETA_MAX_RST = 13'd2458;

  typedef struct packed {
    logic [15:0] top_mass;
    logic [15:0] w_mass;
    logic [15:0] lepton_b_mass;
    logic [15:0] w_weight;
    logic [15:0] top_weight;
    logic [15:0] lepton_b_weight;
    logic [19:0] pt_min;
    logic [12:0] eta_max;
  } cfg_t;

  typedef enum logic [1:0] {K_JET, K_MUON, K_RUN} kind_t;

  typedef struct packed {
    logic [19:0] energy;
    logic [19:0] mom_x;
    logic [19:0] mom_y;
    logic [19:0] mom_z;
  } vec_t;

  typedef struct packed {
    kind_t kind;
    vec_t  v;
    logic  method;
  } entry_t;

  typedef enum logic [1:0] {T_W, T_TOP, T_LEP} term_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_ACC, ST_SQE, ST_SQX, ST_SQY, ST_SQZ, ST_RINIT,
    ST_ROOT, ST_DIFF, ST_DSQ, ST_WT, ST_ADDT, ST_CMP, ST_EMIT
  } back_state_t;

  typedef logic [2:0] jidx_t;
  typedef jidx_t [3:0] tuple_t;

  typedef struct packed {
    logic   more;
    tuple_t t;
  } step_t;

  localparam tuple_t TUPLE_INIT = {3'd3, 3'd2, 3'd1, 3'd0};

  // next lexicographic permutation of the first k entries
  function automatic step_t next_perm(tuple_t p, logic four);
    int k;
    int i;
    int j;
    int m;
    logic found;
    tuple_t q;
    tuple_t r;
    step_t s;
    k = four ? 4 : 3;
    found = 1'b0;
    i = 0;
    j = 0;
    for (m = 0; m < 3; m++) begin
      if (m < k - 1 && p[m] < p[m+1]) begin
        i = m;
        found = 1'b1;
      end
    end
    for (m = 0; m < 4; m++) begin
      if (m < k && m > i && p[m] > p[i]) j = m;
    end
    q = p;
    q[i] = p[j];
    q[j] = p[i];
    r = q;
    for (m = 0; m < 4; m++) begin
      if (m > i && m < k) r[m] = q[2'(k + i - m)];
    end
    s.more = found;
    s.t = r;
    return s;
  endfunction

  // next lexicographic k-subset of 0..n-1
  function automatic step_t next_comb(tuple_t c, logic four, logic [3:0] n);
    int k;
    int i;
    int m;
    logic found;
    tuple_t r;
    step_t s;
    k = four ? 4 : 3;
    found = 1'b0;
    i = 0;
    for (m = 0; m < 4; m++) begin
      if (m < k && int'(c[m]) < int'(n) - k + m) begin
        i = m;
        found = 1'b1;
      end
    end
    r = c;
    for (m = 0; m < 4; m++) begin
      if (m >= i && m < k) r[m] = 3'(int'(c[i]) + 1 + m - i);
    end
    s.more = found;
    s.t = r;
    return s;
  endfunction

endpackage

>>> design/jcs_front.sv
`timescale 1ns / 1ps
module jcs_front (
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        command,
  input  logic [19:0]       energy,
  input  logic signed [19:0] mom_x,
  input  logic signed [19:0] mom_y,
  input  logic signed [19:0] mom_z,
  input  logic [19:0]       trans_mom,
  input  logic [12:0]       abs_eta,
  input  logic              method,
  input  jcs_pkg::cfg_t     cfg,
  input  logic              full,
  output logic              push,
  output jcs_pkg::entry_t   entry
);

  logic keep;

  // drop failing jets and unknown commands here
  always_comb begin
    keep = 1'b0;
    entry.kind = jcs_pkg::K_JET;
    entry.v.energy = energy;
    entry.v.mom_x = mom_x;
    entry.v.mom_y = mom_y;
    entry.v.mom_z = mom_z;
    entry.method = method;
    case (command)
      jcs_pkg::CMD_JET: keep = (abs_eta < cfg.eta_max) && (trans_mom > cfg.pt_min);
      jcs_pkg::CMD_MUON: begin
        keep = 1'b1;
        entry.kind = jcs_pkg::K_MUON;
      end
      jcs_pkg::CMD_RUN: begin
        keep = 1'b1;
        entry.kind = jcs_pkg::K_RUN;
      end
      default: keep = 1'b0;
    endcase
  end

  assign item_stall = full;
  assign push = item_valid && !full && keep;

endmodule

>>> design/jcs_queue.sv
`timescale 1ns / 1ps
module jcs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jcs_pkg::entry_t wdata,
  input  logic            pop,
  output jcs_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = (jcs_pkg::QDEPTH > 1) ? $clog2(jcs_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(jcs_pkg::QDEPTH + 1);

  jcs_pkg::entry_t slots [jcs_pkg::QDEPTH];
  logic [PW-1:0] wr;
  logic [PW-1:0] rd;
  logic [CW-1:0] count;

  assign full = (count == CW'(jcs_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head = slots[rd];

  always_ff @(posedge clk) begin
    if (push) slots[wr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (push) wr <= (wr == PW'(jcs_pkg::QDEPTH - 1)) ? '0 : wr + 1'b1;
      if (pop) rd <= (rd == PW'(jcs_pkg::QDEPTH - 1)) ? '0 : rd + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> design/jcs_back.sv
`timescale 1ns / 1ps
module jcs_back #(
  parameter int MAX_JETS = jcs_pkg::MAX_JETS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  jcs_pkg::cfg_t   cfg,
  input  jcs_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [31:0]     chi_square,
  output logic [2:0]      jet_light_a,
  output logic [2:0]      jet_light_b,
  output logic [2:0]      jet_had_b,
  output logic [2:0]      jet_lep_b,
  output logic            enough_jets
);

  localparam int AW = $clog2(MAX_JETS);
  localparam int CW = $clog2(MAX_JETS + 1);

  jcs_pkg::back_state_t state, state_next;
  jcs_pkg::term_t term;

  jcs_pkg::vec_t store [MAX_JETS];
  jcs_pkg::vec_t rdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  jcs_pkg::vec_t muon;

  logic four;
  logic enough;
  logic [1:0] ridx;
  jcs_pkg::tuple_t c;
  jcs_pkg::tuple_t p;
  jcs_pkg::tuple_t best;
  logic have;
  logic [31:0] best_score;

  logic [21:0] ve;
  logic signed [21:0] vx, vy, vz;
  logic signed [22:0] sq_op;
  logic signed [45:0] sq;
  logic signed [45:0] m2;
  logic neg;
  logic [43:0] rv;
  logic [44:0] rr;
  logic [4:0] s;
  logic [44:0] rbit;
  logic [44:0] trial;
  logic [23:0] ad;
  logic [47:0] d2;
  logic [63:0] tm;
  logic [65:0] acc;

  logic mem_we;
  logic emit;
  logic [15:0] tgt;
  logic [15:0] wgt;
  logic signed [23:0] mass;
  logic signed [24:0] d;
  logic [49:0] sh;
  logic [31:0] score;
  jcs_pkg::step_t pstep;
  jcs_pkg::step_t cstep;
  logic [21:0] je;
  logic signed [21:0] jx, jy, jz, mxe, mye, mze;

  // jet store read port
  assign raddr = p[ridx][AW-1:0];

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
    if (mem_we) store[count[AW-1:0]] <= head.v;
  end

  // control outputs
  always_comb begin
    pop = 1'b0;
    mem_we = 1'b0;
    emit = 1'b0;
    case (state)
      jcs_pkg::ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          mem_we = (head.kind == jcs_pkg::K_JET) && (count < CW'(MAX_JETS));
        end
      end
      jcs_pkg::ST_EMIT: emit = !result_valid || !result_stall;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      jcs_pkg::ST_IDLE: begin
        if (!empty && head.kind == jcs_pkg::K_RUN)
          state_next = (count < CW'(4)) ? jcs_pkg::ST_EMIT : jcs_pkg::ST_RD;
      end
      jcs_pkg::ST_RD: state_next = jcs_pkg::ST_ACC;
      jcs_pkg::ST_ACC: begin
        state_next = (term == jcs_pkg::T_W && ridx == 2'd0) ? jcs_pkg::ST_RD :
                     jcs_pkg::ST_SQE;
      end
      jcs_pkg::ST_SQE: state_next = jcs_pkg::ST_SQX;
      jcs_pkg::ST_SQX: state_next = jcs_pkg::ST_SQY;
      jcs_pkg::ST_SQY: state_next = jcs_pkg::ST_SQZ;
      jcs_pkg::ST_SQZ: state_next = jcs_pkg::ST_RINIT;
      jcs_pkg::ST_RINIT: state_next = jcs_pkg::ST_ROOT;
      jcs_pkg::ST_ROOT: if (s == '0) state_next = jcs_pkg::ST_DIFF;
      jcs_pkg::ST_DIFF: state_next = jcs_pkg::ST_DSQ;
      jcs_pkg::ST_DSQ: state_next = jcs_pkg::ST_WT;
      jcs_pkg::ST_WT: state_next = jcs_pkg::ST_ADDT;
      jcs_pkg::ST_ADDT: begin
        state_next = (term == jcs_pkg::T_W || (term == jcs_pkg::T_TOP && four)) ?
                     jcs_pkg::ST_RD : jcs_pkg::ST_CMP;
      end
      jcs_pkg::ST_CMP: begin
        state_next = (pstep.more || cstep.more) ? jcs_pkg::ST_RD : jcs_pkg::ST_EMIT;
      end
      jcs_pkg::ST_EMIT: if (emit) state_next = jcs_pkg::ST_IDLE;
      default: state_next = jcs_pkg::ST_IDLE;
    endcase
  end

  // datapath helpers
  assign je = {2'b00, rdata.energy};
  assign jx = {{2{rdata.mom_x[19]}}, rdata.mom_x};
  assign jy = {{2{rdata.mom_y[19]}}, rdata.mom_y};
  assign jz = {{2{rdata.mom_z[19]}}, rdata.mom_z};
  assign mxe = {{2{muon.mom_x[19]}}, muon.mom_x};
  assign mye = {{2{muon.mom_y[19]}}, muon.mom_y};
  assign mze = {{2{muon.mom_z[19]}}, muon.mom_z};

  always_comb begin
    case (state)
      jcs_pkg::ST_SQX: sq_op = {vx[21], vx};
      jcs_pkg::ST_SQY: sq_op = {vy[21], vy};
      jcs_pkg::ST_SQZ: sq_op = {vz[21], vz};
      default: sq_op = $signed({1'b0, ve});
    endcase
  end
  assign sq = sq_op * sq_op;

  assign rbit = 45'(1) << {s, 1'b0};
  assign trial = rr + rbit;

  always_comb begin
    case (term)
      jcs_pkg::T_TOP: begin
        tgt = cfg.top_mass;
        wgt = cfg.top_weight;
      end
      jcs_pkg::T_LEP: begin
        tgt = cfg.lepton_b_mass;
        wgt = cfg.lepton_b_weight;
      end
      default: begin
        tgt = cfg.w_mass;
        wgt = cfg.w_weight;
      end
    endcase
  end

  assign mass = neg ? -$signed({2'b00, rr[21:0]}) : $signed({2'b00, rr[21:0]});
  assign d = {mass[23], mass} - $signed({9'd0, tgt});
  assign sh = acc[65:16];
  assign score = (|sh[49:32]) ? 32'hFFFF_FFFF : sh[31:0];
  assign pstep = jcs_pkg::next_perm(p, four);
  assign cstep = jcs_pkg::next_comb(c, four, 4'(n));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jcs_pkg::ST_IDLE;
      count <= '0;
      muon <= '0;
    end else begin
      state <= state_next;
      if (mem_we) count <= count + 1'b1;
      if (pop && head.kind == jcs_pkg::K_MUON) muon <= head.v;
      if (pop && head.kind == jcs_pkg::K_RUN) count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      jcs_pkg::ST_IDLE: begin
        if (pop && head.kind == jcs_pkg::K_RUN) begin
          four <= head.method;
          n <= count;
          enough <= (count >= CW'(4));
          c <= jcs_pkg::TUPLE_INIT;
          p <= jcs_pkg::TUPLE_INIT;
          ridx <= 2'd0;
          term <= jcs_pkg::T_W;
          acc <= '0;
          have <= 1'b0;
          best_score <= '0;
          best <= '0;
        end
      end
      jcs_pkg::ST_ACC: begin
        if (term == jcs_pkg::T_LEP) begin
          ve <= je + {2'b00, muon.energy};
          vx <= jx + mxe;
          vy <= jy + mye;
          vz <= jz + mze;
        end else if (term == jcs_pkg::T_W && ridx == 2'd0) begin
          ve <= je;
          vx <= jx;
          vy <= jy;
          vz <= jz;
          ridx <= 2'd1;
        end else begin
          ve <= ve + je;
          vx <= vx + jx;
          vy <= vy + jy;
          vz <= vz + jz;
        end
      end
      jcs_pkg::ST_SQE: m2 <= sq;
      jcs_pkg::ST_SQX, jcs_pkg::ST_SQY, jcs_pkg::ST_SQZ: m2 <= m2 - sq;
      jcs_pkg::ST_RINIT: begin
        neg <= m2[45];
        rv <= m2[45] ? 44'(-m2) : m2[43:0];
        rr <= '0;
        s <= 5'd21;
      end
      jcs_pkg::ST_ROOT: begin
        if ({1'b0, rv} >= trial) begin
          rv <= rv - trial[43:0];
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        s <= s - 1'b1;
      end
      jcs_pkg::ST_DIFF: ad <= d[24] ? 24'(-d) : d[23:0];
      jcs_pkg::ST_DSQ: d2 <= ad * ad;
      jcs_pkg::ST_WT: tm <= d2 * wgt;
      jcs_pkg::ST_ADDT: begin
        acc <= acc + {2'b00, tm};
        if (term == jcs_pkg::T_W) begin
          term <= jcs_pkg::T_TOP;
          ridx <= 2'd2;
        end else if (term == jcs_pkg::T_TOP && four) begin
          term <= jcs_pkg::T_LEP;
          ridx <= 2'd3;
        end
      end
      jcs_pkg::ST_CMP: begin
        // strict compare keeps the earliest choice on ties
        if (!have || score < best_score) begin
          have <= 1'b1;
          best_score <= score;
          best <= p;
        end
        if (pstep.more) begin
          p <= pstep.t;
        end else if (cstep.more) begin
          c <= cstep.t;
          p <= cstep.t;
        end
        term <= jcs_pkg::T_W;
        ridx <= 2'd0;
        acc <= '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chi_square <= enough ? best_score : '0;
      jet_light_a <= enough ? best[0] : '0;
      jet_light_b <= enough ? best[1] : '0;
      jet_had_b <= enough ? best[2] : '0;
      jet_lep_b <= (enough && four) ? best[3] : '0;
      enough_jets <= enough;
    end
  end

endmodule

>>> design/jet_combination_chi_square_search.sv
`timescale 1ns / 1ps
// Jet combination chi-square search.
// Input channel (item_valid / item_stall): one transfer per command. Jet and
// muon loads are taken one per cycle while item_stall is low; a jet failing
// the pt / eta cut or an unknown command is dropped at the input, a passing
// jet beyond MAX_JETS is dropped when it reaches the store.
// A run command scores every ordered choice of 3 (method 0) or 4 (method 1)
// stored jets, up to 360 choices for six jets in method 1. Each mass term of a
// choice takes store reads, four squarings through one multiplier, a 22-step
// square root and weighting. Fewer than four stored jets skips the search and
// goes straight to the result.
// Output channel (result_valid / result_stall): one transfer per run command.
// The result holds in its register while result_stall is high; loads keep
// flowing into the two-entry queue until it fills, then item_stall rises.
// Reset (rst, synchronous) empties the queue and jet store, clears the muon
// and restores register defaults. Configuration writes are taken any cycle.
module jet_combination_chi_square_search #(
  parameter int MAX_JETS = jcs_pkg::MAX_JETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [2:0]         register_index,
  input  logic [19:0]        write_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [19:0]        energy,
  input  logic signed [19:0] mom_x,
  input  logic signed [19:0] mom_y,
  input  logic signed [19:0] mom_z,
  input  logic [19:0]        trans_mom,
  input  logic [12:0]        abs_eta,
  input  logic               method,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        chi_square,
  output logic [2:0]         jet_light_a,
  output logic [2:0]         jet_light_b,
  output logic [2:0]         jet_had_b,
  output logic [2:0]         jet_lep_b,
  output logic               enough_jets
);

  jcs_pkg::cfg_t cfg;
  jcs_pkg::entry_t entry;
  jcs_pkg::entry_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_mass <= jcs_pkg::TOP_MASS_RST;
      cfg.w_mass <= jcs_pkg::W_MASS_RST;
      cfg.lepton_b_mass <= jcs_pkg::LEP_B_MASS_RST;
      cfg.w_weight <= jcs_pkg::W_WEIGHT_RST;
      cfg.top_weight <= jcs_pkg::TOP_WEIGHT_RST;
      cfg.lepton_b_weight <= jcs_pkg::LEP_B_WEIGHT_RST;
      cfg.pt_min <= jcs_pkg::PT_MIN_RST;
      cfg.eta_max <= jcs_pkg::ETA_MAX_RST;
    end else if (write_enable) begin
      case (register_index)
        jcs_pkg::REG_TOP_MASS: cfg.top_mass <= write_data[15:0];
        jcs_pkg::REG_W_MASS: cfg.w_mass <= write_data[15:0];
        jcs_pkg::REG_LEP_B_MASS: cfg.lepton_b_mass <= write_data[15:0];
        jcs_pkg::REG_W_WEIGHT: cfg.w_weight <= write_data[15:0];
        jcs_pkg::REG_TOP_WEIGHT: cfg.top_weight <= write_data[15:0];
        jcs_pkg::REG_LEP_B_WEIGHT: cfg.lepton_b_weight <= write_data[15:0];
        jcs_pkg::REG_PT_MIN: cfg.pt_min <= write_data;
        jcs_pkg::REG_ETA_MAX: cfg.eta_max <= write_data[12:0];
        default: ;
      endcase
    end
  end

  // classify and filter at the input
  jcs_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .energy     (energy),
    .mom_x      (mom_x),
    .mom_y      (mom_y),
    .mom_z      (mom_z),
    .trans_mom  (trans_mom),
    .abs_eta    (abs_eta),
    .method     (method),
    .cfg        (cfg),
    .full       (full),
    .push       (push),
    .entry      (entry)
  );

  // decouple input from the search engine
  jcs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  // jet store, muon and search sequencer
  jcs_back #(
    .MAX_JETS (MAX_JETS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .chi_square   (chi_square),
    .jet_light_a  (jet_light_a),
    .jet_light_b  (jet_light_b),
    .jet_had_b    (jet_had_b),
    .jet_lep_b    (jet_lep_b),
    .enough_jets  (enough_jets)
  );

endmodule
